>>> hdl/msq_pkg.sv
package msq_pkg;

    localparam int SIDE_W        = 11;
    localparam int AREA_W        = 21;
    localparam int CFG_W         = 11;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam logic [CFG_W-1:0]  WIDTH_RST = CFG_W'(1024);
    localparam logic [SIDE_W-1:0] SIDE_MAX  = {SIDE_W{1'b1}};
    localparam logic [AREA_W-1:0] AREA_MAX  = {AREA_W{1'b1}};

    typedef logic [SIDE_W-1:0] side_t;
    typedef logic [AREA_W-1:0] area_t;

endpackage

>>> hdl/maximal_square_of_ones.sv
// m_axis_tvalid rises once the tlast beat has passed stage B, result and output registers.
// One pixel per cycle unless stalled; line store reads at accept, writes as stage B fires.
// Input stalls only while a finished result and the one behind it both wait downstream.
// Reset: control state cleared, image_width = 1024, next pixel starts a new image.
// The line store is not cleared; the first row of an image never reads it.
module maximal_square_of_ones #(
    parameter int MAX_WIDTH = msq_pkg::MAX_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [msq_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [0] pixel, rest zero
    input  logic                      s_axis_tlast,   // last_pixel
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [31:0]               m_axis_tdata    // [20:0] square_area, [31:21] square_side
);

    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int SW     = msq_pkg::SIDE_W;
    localparam int PROD_W = 2 * SW;

    // configuration
    logic [msq_pkg::CFG_W-1:0] width_reg;
    logic [WW-1:0]             w_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= msq_pkg::WIDTH_RST;
        end
        else if (cfg_we)
        begin
            width_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        priority if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
    end

    // stage A: column tracking and line-store read
    logic          s_accept;
    logic [CW-1:0] col_reg;
    logic          first_reg;
    logic          col_over;
    logic [CW-1:0] col_cur;
    logic          first_cur;
    logic [WW-1:0] col_inc;
    logic          row_wrap;
    logic [CW-1:0] col_next;
    logic          first_next;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign col_over  = WW'(col_reg) >= w_eff;
    assign col_cur   = col_over ? '0 : col_reg;
    assign first_cur = col_over ? 1'b0 : first_reg;
    assign col_inc   = WW'(col_cur) + WW'(1);
    assign row_wrap  = col_inc >= w_eff;

    always_comb
    begin
        priority if (s_axis_tlast)
        begin
            col_next   = '0;
            first_next = 1'b1;
        end
        else if (row_wrap)
        begin
            col_next   = '0;
            first_next = 1'b0;
        end
        else
        begin
            col_next   = CW'(col_inc);
            first_next = first_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (s_accept)
        begin
            col_reg   <= col_next;
            first_reg <= first_next;
        end
    end

    // stage B registers
    logic          b_valid_reg;
    logic          b_pixel_reg;
    logic          b_last_reg;
    logic [CW-1:0] b_col_reg;
    logic          b_first_reg;
    logic          b_go;
    logic          b_fire;

    msq_pkg::side_t left_reg;
    msq_pkg::side_t diag_reg;
    msq_pkg::side_t best_reg;
    msq_pkg::side_t best_next;
    msq_pkg::side_t side;
    msq_pkg::side_t up;
    msq_pkg::side_t left;
    msq_pkg::side_t diag;
    msq_pkg::side_t min_ld;
    msq_pkg::side_t min3;
    logic [SW:0]    sum;

    logic           fwd_reg;
    msq_pkg::side_t fwd_side_reg;
    msq_pkg::side_t mem_rd_reg;
    msq_pkg::side_t line_mem [MAX_WIDTH];

    // result and output registers
    logic           r_valid_reg;
    msq_pkg::side_t r_side_reg;
    logic           r_move;
    logic           o_valid_reg;
    msq_pkg::side_t o_side_reg;
    msq_pkg::area_t o_area_reg;
    logic [PROD_W-1:0] prod;
    msq_pkg::area_t    area_sat;

    assign r_move        = r_valid_reg && (!o_valid_reg || m_axis_tready);
    assign b_go          = !b_last_reg || !r_valid_reg || r_move;
    assign b_fire        = b_valid_reg && b_go;
    assign s_axis_tready = !b_valid_reg || b_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_last_reg  <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            b_valid_reg <= s_accept;
            if (s_accept)
            begin
                b_last_reg <= s_axis_tlast;
            end
        end
    end

    // payload of stage B and forwarding for a same-entry write during the read
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            b_pixel_reg  <= s_axis_tdata[0];
            b_col_reg    <= col_cur;
            b_first_reg  <= first_cur;
            fwd_reg      <= b_fire && (b_col_reg == col_cur);
            fwd_side_reg <= side;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            line_mem[b_col_reg] <= side;
        end
        if (s_accept)
        begin
            mem_rd_reg <= line_mem[col_cur];
        end
    end

    always_comb
    begin
        up     = b_first_reg ? '0 : (fwd_reg ? fwd_side_reg : mem_rd_reg);
        left   = (b_col_reg == '0) ? '0 : left_reg;
        diag   = (b_col_reg == '0 || b_first_reg) ? '0 : diag_reg;
        min_ld = (left < diag) ? left : diag;
        min3   = (up < min_ld) ? up : min_ld;
        sum    = {1'b0, min3} + (SW + 1)'(1);
        if (!b_pixel_reg)
        begin
            side = '0;
        end
        else if (sum[SW])
        begin
            side = msq_pkg::SIDE_MAX;
        end
        else
        begin
            side = sum[SW-1:0];
        end
        best_next = (side > best_reg) ? side : best_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            diag_reg <= '0;
            best_reg <= '0;
        end
        else if (b_fire)
        begin
            left_reg <= side;
            diag_reg <= up;
            best_reg <= b_last_reg ? '0 : best_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else
        begin
            r_valid_reg <= (r_valid_reg && !r_move) || (b_fire && b_last_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire && b_last_reg)
        begin
            r_side_reg <= best_next;
        end
    end

    assign prod     = PROD_W'(r_side_reg) * PROD_W'(r_side_reg);
    assign area_sat = (prod > PROD_W'(msq_pkg::AREA_MAX)) ? msq_pkg::AREA_MAX
                                                        : prod[msq_pkg::AREA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= (o_valid_reg && !m_axis_tready) || r_move;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_move)
        begin
            o_side_reg <= r_side_reg;
            o_area_reg <= area_sat;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {o_side_reg, o_area_reg};

    // a pixel in stage B only waits when it closes an image
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !b_go) |-> b_last_reg)
        else $error("stage B stalled on a pixel that is not last");

    // closing pixel hands its best side over and rearms the tracker
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_fire && b_last_reg) |=> (r_valid_reg && r_side_reg == $past(best_next)
                                    && best_reg == '0))
        else $error("result not captured or best side not rearmed");

    // forwarded side always comes from the beat written in the read cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && b_fire && b_col_reg == col_cur) |=> fwd_reg)
        else $error("same-entry line store access not forwarded");

endmodule

>>> bench/msq_checker.sv
module msq_checker #(
    parameter int MAX_WIDTH = msq_pkg::MAX_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [msq_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [7:0]                s_tdata,
    input  logic                      s_tlast,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [31:0]               m_tdata,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        msq_pkg::area_t area;
        msq_pkg::side_t side;
    } square_t;

    square_t                   squares_due[$];
    logic [msq_pkg::CFG_W-1:0] row_width;
    msq_pkg::side_t            line_sides[MAX_WIDTH];
    msq_pkg::side_t            left_side;
    msq_pkg::side_t            diag_side;
    msq_pkg::side_t            best_side;
    int unsigned               col_idx;
    logic                      first_row;
    int                        results_seen;

    task automatic rearm_image;
        left_side = '0;
        diag_side = '0;
        col_idx   = 0;
        first_row = 1'b1;
        best_side = '0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 40)
            $display("%t mismatch on result %0d, %s: got %0d, expected %0d",
                     $realtime, results_seen, what, got, want);
        fail_count++;
    endtask

    // one pixel of the largest-square recurrence; queues a result on the last pixel
    task automatic take_pixel(input logic pix, input logic lst);
        int unsigned    eff_width;
        int unsigned    col;
        msq_pkg::side_t up;
        msq_pkg::side_t lft;
        msq_pkg::side_t dia;
        msq_pkg::side_t side;
        int unsigned    area;
        square_t        sq;
        if (row_width == 0)
            eff_width = 1;
        else if (row_width > MAX_WIDTH)
            eff_width = MAX_WIDTH;
        else
            eff_width = row_width;
        if (col_idx >= eff_width)
        begin
            col_idx   = 0;
            first_row = 1'b0;
        end
        col = col_idx;
        up  = first_row ? '0 : line_sides[col];
        lft = (col == 0) ? '0 : left_side;
        dia = (col == 0 || first_row) ? '0 : diag_side;
        if (pix)
        begin
            side = (up < lft) ? up : lft;
            side = (dia < side) ? dia : side;
            side = (side == msq_pkg::SIDE_MAX) ? msq_pkg::SIDE_MAX : side + 1'b1;
        end
        else
            side = '0;
        line_sides[col] = side;
        diag_side = up;
        left_side = side;
        if (side > best_side)
            best_side = side;
        col_idx = col + 1;
        if (col_idx >= eff_width)
        begin
            col_idx   = 0;
            first_row = 1'b0;
        end
        if (lst)
        begin
            area = int'(best_side) * int'(best_side);
            sq.area = (area > int'(msq_pkg::AREA_MAX)) ? msq_pkg::AREA_MAX
                                                      : msq_pkg::area_t'(area);
            sq.side = best_side;
            squares_due.push_back(sq);
            rearm_image();
        end
    endtask

    task automatic check_square(input logic [31:0] beat);
        square_t want;
        if (squares_due.size() == 0)
        begin
            report_mismatch("result with no image pending", int'(beat), 0);
            return;
        end
        want = squares_due.pop_front();
        if (beat[msq_pkg::AREA_W-1:0] !== want.area)
            report_mismatch("square_area", int'(beat[msq_pkg::AREA_W-1:0]), int'(want.area));
        if (beat[msq_pkg::AREA_W +: msq_pkg::SIDE_W] !== want.side)
            report_mismatch("square_side", int'(beat[msq_pkg::AREA_W +: msq_pkg::SIDE_W]),
                            int'(want.side));
        results_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width = msq_pkg::WIDTH_RST;
            rearm_image();
            squares_due.delete();
            fail_count   = 0;
            results_seen = 0;
            pending <= 0;
        end
        else
        begin
            // results first: nothing accepted this edge can already be out
            if (m_tvalid && m_tready)
                check_square(m_tdata);
            if (cfg_we)
                row_width = cfg_wdata;
            if (s_tvalid && s_tready)
                take_pixel(s_tdata[0], s_tlast);
            pending <= squares_due.size();
        end
    end

endmodule

>>> bench/maximal_square_of_ones_test.sv
module maximal_square_of_ones_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT     = 400000;
    localparam int PHASES        = 12;
    localparam int LONG_ROW_PHASE = 3;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_we        = 1'b0;
    logic [msq_pkg::CFG_W-1:0] cfg_wdata     = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata  = '0;
    logic                      s_axis_tlast  = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [31:0]               m_axis_tdata;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int beats_sent    = 0;
    int images_sent   = 0;

    int phase_width[PHASES] = '{4, 1, 8, 2047, 16, 6, 1025, 3, 12, 2, 31, 9};

    maximal_square_of_ones u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    msq_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tlast    (s_axis_tlast),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // leaves tvalid high after the beat; the next call or drain decides what follows
    task automatic send_pixel(input logic pix, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, pix};
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beats_sent++;
        if (lst)
            images_sent++;
    endtask

    task automatic send_image(input int len, input int density);
        for (int i = 0; i < len; i++)
            send_pixel($urandom_range(99) < density, i == len - 1);
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_width(input int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= msq_pkg::CFG_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int eff;
        int len;
        int density;
        int phase_beats;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width: single-pixel images, set and clear
        send_pixel(1'b1, 1'b1);
        send_pixel(1'b0, 1'b1);
        drain_results();
        // zero width acts as one: a column, left and diagonal never count
        write_width(0);
        send_image(4, 100);
        drain_results();
        write_width(2);
        send_image(4, 100);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b0, 1'b0);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b1);
        drain_results();
        write_width(3);
        send_image(9, 100);
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            write_width(phase_width[p]);
            eff = (phase_width[p] == 0) ? 1 :
                  (phase_width[p] > msq_pkg::MAX_WIDTH_DEF) ? msq_pkg::MAX_WIDTH_DEF
                                                            : phase_width[p];
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            phase_beats = beats_sent;
            if (p == LONG_ROW_PHASE)
                send_image(eff + $urandom_range(1, 40), 97);
            while (beats_sent - phase_beats < ((eff > 64) ? 60 : 100))
            begin
                case ($urandom_range(3))
                    0: density = 40;
                    1: density = 80;
                    2: density = 95;
                    default: density = 100;
                endcase
                if (eff > 64)
                    len = $urandom_range(1, 40);
                else if ($urandom_range(7) == 0)
                begin
                    // noise: short ragged image
                    len = $urandom_range(1, 40);
                    density = 50;
                end
                else
                begin
                    len = eff * $urandom_range(1, 10);
                    if ($urandom_range(3) == 0)
                        len = len - $urandom_range(0, eff - 1);
                    if (len < 1)
                        len = 1;
                end
                send_image(len, density);
                if ($urandom_range(7) == 0)
                    drain_results();
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        $display("covered %0d images in %0d pixel beats over %0d row-width settings",
                 images_sent, beats_sent, PHASES + 4);
        $display("widths 0 through 2047 incl. clamped ones, four source/sink stall mixes");
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
